@@ hdl/nce_pkg.sv @@
// Shared constants, field types and codes for the nihilist cipher engine.
`timescale 1ns / 1ps

package nce_pkg;

    // Store depths
    localparam int MAX_SYMBOLS = 81;
    localparam int KEY_DEPTH   = 64;

    // Derived widths
    localparam int ALPHA_AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int ALPHA_CW = $clog2(MAX_SYMBOLS + 1);
    localparam int KEY_AW   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KEY_LW   = $clog2(KEY_DEPTH + 1);

    // Field widths
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 7;
    localparam int SYM_W    = 8;
    localparam int STAT_W   = 3;
    localparam int CODE_W   = 7;
    localparam int SQ_W     = 4;
    localparam int ALEN_W   = 7;
    localparam int KLEN_W   = 7;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 7;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [CFG_IW-1:0] t_cfg_idx;
    typedef logic [CFG_DW-1:0] t_cfg_data;

    // Commands
    localparam t_cmd CMD_ALPHA = 2'd0;
    localparam t_cmd CMD_KEY   = 2'd1;
    localparam t_cmd CMD_DATA  = 2'd2;
    localparam t_cmd CMD_NONE  = 2'd3;

    // Status codes
    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_SQUARE  = 3'd1;
    localparam t_status ST_ALPHA   = 3'd2;
    localparam t_status ST_UNKNOWN = 3'd3;
    localparam t_status ST_BADCODE = 3'd4;

    // Configuration register indexes
    localparam t_cfg_idx REG_SQUARE_SIZE = 3'd0;
    localparam t_cfg_idx REG_ALPHA_LEN   = 3'd1;
    localparam t_cfg_idx REG_KEY_LEN     = 3'd2;
    localparam t_cfg_idx REG_DIRECTION   = 3'd3;

    // Register reset values
    localparam logic [SQ_W-1:0]   RST_SQUARE_SIZE = 4'd5;
    localparam logic [ALEN_W-1:0] RST_ALPHA_LEN   = 7'd25;
    localparam logic [KLEN_W-1:0] RST_KEY_LEN     = 7'd1;

endpackage

@@ hdl/nce_ifs.sv @@
// Valid/ready channel interfaces for the nihilist cipher engine.
`timescale 1ns / 1ps

interface nce_req_if;
    logic           valid;
    logic           ready;
    nce_pkg::t_cmd  command;
    nce_pkg::t_slot slot;
    nce_pkg::t_sym  symbol;
    logic           restart;

    modport source (output valid, command, slot, symbol, restart, input ready);
    modport sink   (input valid, command, slot, symbol, restart, output ready);
endinterface

interface nce_rsp_if;
    logic             valid;
    logic             ready;
    nce_pkg::t_sym    value_out;
    nce_pkg::t_status status;

    modport source (output valid, value_out, status, input ready);
    modport sink   (input valid, value_out, status, output ready);
endinterface

interface nce_cfg_if;
    logic               valid;
    logic               ready;
    nce_pkg::t_cfg_idx  index;
    nce_pkg::t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/nihilist_cipher_engine.sv @@
// Nihilist cipher engine top level: sequencer, shared search/compare unit, stores.
`timescale 1ns / 1ps
//
//  Channel   Dir   Beat payload                        Notes
//  i_req     in    command, slot, symbol, restart      ready only in IDLE
//  o_rsp     out   value_out, status                   one beat per request
//  i_cfg     in    index, data                         always ready
//
//  Alphabet load, unused command and unused key slot go straight to DONE. Key
//  load and encrypt run a linear search over n = min(alphabet_length, 81)
//  entries, one entry compared per cycle via the registered read port.
//  Decrypt steps: key read, split, index check, table read.
//  Reset clears control state and key-entry valid bits at once, no clearing
//  pass. A stalled o_rsp holds its register; a new request still enters, and
//  waits in DONE.

module nihilist_cipher_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nce_req_if.sink      i_req,
    nce_rsp_if.source    o_rsp,
    nce_cfg_if.sink      i_cfg
);

    localparam int ALPHA_AW    = nce_pkg::ALPHA_AW;
    localparam int ALPHA_CW    = nce_pkg::ALPHA_CW;
    localparam int KEY_AW      = nce_pkg::KEY_AW;
    localparam int KEY_LW      = nce_pkg::KEY_LW;
    localparam int CODE_W      = nce_pkg::CODE_W;
    localparam int SYM_W       = nce_pkg::SYM_W;
    localparam int SQ_W        = nce_pkg::SQ_W;
    localparam int KEY_DEPTH_W = nce_pkg::KEY_DEPTH;

    // divide by 10 as multiply by 205 then >> 11, exact for 0..255
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_KEYRD  = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_SPLIT  = 3'd4;
    localparam logic [2:0] S_INDEX  = 3'd5;
    localparam logic [2:0] S_ALRD   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    // configuration
    logic [SQ_W-1:0]            r_square;
    logic [nce_pkg::ALEN_W-1:0] r_alen;
    logic [nce_pkg::KLEN_W-1:0] r_klen;
    logic                       r_dir;

    // control
    logic [2:0]             r_state, n_state;
    nce_pkg::t_cmd          r_cmd, n_cmd;
    nce_pkg::t_sym          r_sym, n_sym;
    logic [KEY_AW-1:0]      r_kaddr, n_kaddr;
    logic [KEY_AW-1:0]      r_kpos, n_kpos;
    logic [CODE_W-1:0]      r_kc, n_kc;
    logic                   r_kwr, n_kwr;
    logic [CODE_W-1:0]      r_code, n_code;
    logic [ALPHA_CW-1:0]    r_addr, n_addr;
    logic                   r_pend, n_pend;
    logic [4:0]             r_row, n_row;
    logic [SQ_W-1:0]        r_col, n_col;
    logic [SYM_W-1:0]       r_d, n_d;
    nce_pkg::t_sym          r_value, n_value;
    nce_pkg::t_status       r_status, n_status;
    logic [KEY_DEPTH_W-1:0] r_kvalid;

    // output register
    logic             r_ovalid, n_ovalid;
    nce_pkg::t_sym    r_ovalue, n_ovalue;
    nce_pkg::t_status r_ostatus, n_ostatus;

    // stores
    logic [SYM_W-1:0]  alpha_mem [nce_pkg::MAX_SYMBOLS];
    logic [CODE_W-1:0] key_mem   [nce_pkg::KEY_DEPTH];
    logic [SYM_W-1:0]  r_rdata;
    logic [CODE_W-1:0] r_kdata;
    logic              r_kvld_q;

    logic                in_acc;
    logic                out_free;
    logic                alpha_we;
    logic [ALPHA_AW-1:0] alpha_waddr;
    logic [ALPHA_AW-1:0] alpha_raddr;
    logic                key_we;

    // shared derived values
    logic [7:0]          sq_sq;
    nce_pkg::t_status    cfg_err;
    logic [ALPHA_CW-1:0] nsearch;
    logic [KEY_LW-1:0]   eff_len;
    logic [KEY_AW-1:0]   kp_use;
    logic [KEY_LW:0]     kp_inc;
    logic [CODE_W-1:0]   kc_eff;
    logic [CODE_W-1:0]   hit_code;
    logic [15:0]         div_prod;
    logic [4:0]          div_row;
    logic [7:0]          idx_pos;
    logic                idx_bad;
    logic [SQ_W-1:0]     sq_m1;

    assign in_acc      = i_req.valid & i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_free    = ~r_ovalid | o_rsp.ready;

    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.value_out = r_ovalue;
    assign o_rsp.status    = r_ostatus;

    // configuration checks: alphabet size beats square size in priority
    assign sq_sq = 8'(r_square) * 8'(r_square);
    always_comb begin
        if (8'(r_alen) > sq_sq) begin
            cfg_err = nce_pkg::ST_ALPHA;
        end else if (r_square > 4'd9) begin
            cfg_err = nce_pkg::ST_SQUARE;
        end else begin
            cfg_err = nce_pkg::ST_OK;
        end
    end

    assign nsearch = (32'(r_alen) < nce_pkg::MAX_SYMBOLS) ? ALPHA_CW'(r_alen)
                                                          : ALPHA_CW'(nce_pkg::MAX_SYMBOLS);

    always_comb begin
        if (r_klen == '0) begin
            eff_len = KEY_LW'(1);
        end else if (32'(r_klen) > nce_pkg::KEY_DEPTH) begin
            eff_len = KEY_LW'(nce_pkg::KEY_DEPTH);
        end else begin
            eff_len = KEY_LW'(r_klen);
        end
    end

    // key position used by this data beat, and the one after it
    assign kp_use = (i_req.restart || (KEY_LW'(r_kpos) >= eff_len)) ? '0 : r_kpos;
    assign kp_inc = (KEY_LW + 1)'(kp_use) + 1'b1;

    assign kc_eff   = r_kvld_q ? r_kdata : '0;
    assign hit_code = CODE_W'(r_row) * CODE_W'(10) + CODE_W'(10)
                    + CODE_W'(r_col) + CODE_W'(1);
    assign sq_m1    = r_square - 1'b1;

    // decrypt split: tens digit by reciprocal multiply
    assign div_prod = 16'(r_d) * 16'(DIV10_MUL);
    assign div_row  = 5'(div_prod >> DIV10_SHIFT);

    // decrypt index check and table position
    always_comb begin
        idx_bad = (r_col == '0) || (r_row == '0)
               || (5'(r_col) > 5'(r_square)) || (r_row > 5'(r_square));
        idx_pos = 8'(r_row - 5'd1) * 8'(r_square) + 8'(r_col - 1'b1);
        if (!idx_bad && (32'(idx_pos) >= 32'(nsearch))) begin
            idx_bad = 1'b1;
        end
    end

    assign alpha_raddr = (r_state == S_INDEX) ? ALPHA_AW'(idx_pos) : ALPHA_AW'(r_addr);
    assign alpha_we    = in_acc && (i_req.command == nce_pkg::CMD_ALPHA)
                      && (32'(i_req.slot) < nce_pkg::MAX_SYMBOLS);
    assign alpha_waddr = ALPHA_AW'(i_req.slot);
    assign key_we      = (r_state == S_DONE) && out_free && r_kwr;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_sym    = r_sym;
        n_kaddr  = r_kaddr;
        n_kpos   = r_kpos;
        n_kc     = r_kc;
        n_kwr    = r_kwr;
        n_code   = r_code;
        n_addr   = r_addr;
        n_pend   = r_pend;
        n_row    = r_row;
        n_col    = r_col;
        n_d      = r_d;
        n_value  = r_value;
        n_status = r_status;
        n_ovalid  = r_ovalid & ~o_rsp.ready;
        n_ovalue  = r_ovalue;
        n_ostatus = r_ostatus;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd    = i_req.command;
                    n_sym    = i_req.symbol;
                    n_value  = '0;
                    n_status = nce_pkg::ST_OK;
                    n_code   = '0;
                    n_kwr    = 1'b0;
                    n_addr   = '0;
                    n_pend   = 1'b0;
                    n_row    = '0;
                    n_col    = '0;
                    n_state  = S_DONE;
                    if (i_req.command == nce_pkg::CMD_KEY) begin
                        if (32'(i_req.slot) < nce_pkg::KEY_DEPTH) begin
                            n_kaddr  = KEY_AW'(i_req.slot);
                            n_kwr    = 1'b1;
                            n_status = cfg_err;
                            if (cfg_err == nce_pkg::ST_OK) begin
                                n_state = S_SEARCH;
                            end
                        end
                    end else if (i_req.command == nce_pkg::CMD_DATA) begin
                        n_kaddr = kp_use;
                        n_kpos  = (kp_inc >= (KEY_LW + 1)'(eff_len)) ? '0 : KEY_AW'(kp_inc);
                        n_state = S_KEYRD;
                    end
                end
            end

            S_KEYRD: begin
                n_state = S_CHECK;
            end

            S_CHECK: begin
                n_kc = kc_eff;
                n_d  = r_sym - SYM_W'(kc_eff);
                if (cfg_err != nce_pkg::ST_OK) begin
                    n_status = cfg_err;
                    n_state  = S_DONE;
                end else if (kc_eff == '0) begin
                    n_status = nce_pkg::ST_UNKNOWN;
                    n_state  = S_DONE;
                end else if (!r_dir) begin
                    n_state = S_SEARCH;
                end else begin
                    n_state = S_SPLIT;
                end
            end

            // one alphabet entry compared per cycle, each read in the cycle before its compare
            S_SEARCH: begin
                if (r_pend && (r_rdata == r_sym)) begin
                    n_pend = 1'b0;
                    if (r_cmd == nce_pkg::CMD_KEY) begin
                        n_code = hit_code;
                    end else begin
                        n_value = SYM_W'(hit_code) + SYM_W'(r_kc);
                    end
                    n_state = S_DONE;
                end else if (!r_pend && (r_addr >= nsearch)) begin
                    n_status = nce_pkg::ST_UNKNOWN;
                    n_state  = S_DONE;
                end else begin
                    if (r_pend) begin
                        if (r_col == sq_m1) begin
                            n_col = '0;
                            n_row = r_row + 5'd1;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                    if (r_addr < nsearch) begin
                        n_addr = r_addr + 1'b1;
                        n_pend = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                end
            end

            S_SPLIT: begin
                n_row   = div_row;
                n_col   = SQ_W'(r_d - SYM_W'(div_row) * SYM_W'(10));
                n_state = S_INDEX;
            end

            S_INDEX: begin
                if (idx_bad) begin
                    n_status = nce_pkg::ST_BADCODE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_ALRD;
                end
            end

            S_ALRD: begin
                n_value = r_rdata;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ovalue  = r_value;
                    n_ostatus = r_status;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kpos   <= '0;
            r_kwr    <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_kvalid <= '0;
            r_square <= nce_pkg::RST_SQUARE_SIZE;
            r_alen   <= nce_pkg::RST_ALPHA_LEN;
            r_klen   <= nce_pkg::RST_KEY_LEN;
            r_dir    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kpos   <= n_kpos;
            r_kwr    <= n_kwr;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (key_we) begin
                r_kvalid[r_kaddr] <= 1'b1;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    nce_pkg::REG_SQUARE_SIZE: r_square <= SQ_W'(i_cfg.data);
                    nce_pkg::REG_ALPHA_LEN:   r_alen   <= nce_pkg::ALEN_W'(i_cfg.data);
                    nce_pkg::REG_KEY_LEN:     r_klen   <= nce_pkg::KLEN_W'(i_cfg.data);
                    nce_pkg::REG_DIRECTION:   r_dir    <= i_cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_sym     <= n_sym;
        r_kaddr   <= n_kaddr;
        r_kc      <= n_kc;
        r_code    <= n_code;
        r_addr    <= n_addr;
        r_row     <= n_row;
        r_col     <= n_col;
        r_d       <= n_d;
        r_value   <= n_value;
        r_status  <= n_status;
        r_ovalue  <= n_ovalue;
        r_ostatus <= n_ostatus;
    end

    // alphabet store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (alpha_we) begin
            alpha_mem[alpha_waddr] <= i_req.symbol;
        end
        r_rdata <= alpha_mem[alpha_raddr];
    end

    // key code store; entries without a valid bit read as zero
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[r_kaddr] <= r_code;
        end
        r_kdata  <= key_mem[r_kaddr];
        r_kvld_q <= r_kvalid[r_kaddr];
    end

endmodule
